// File: design/postfix_expression_evaluator_top_macros.svh
// Assertion macros for the postfix expression evaluator.
// Used by the top level; no other dependencies.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PEE_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("pee check failed");
`define PEE_ASSERT_RESET(label, clk, sig) \
    label: assert property (@(posedge clk) sig) else $error("pee reset check failed");
`else
`define PEE_ASSERT_IMPL(label, clk, rst_n, prop)
`define PEE_ASSERT_RESET(label, clk, sig)
`endif
`endif

// File: design/pee_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pee_pkg;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
    localparam logic [2:0] ERR_DIVZERO   = 3'd3;
    localparam logic [2:0] ERR_TOOLARGE  = 3'd4;

    localparam logic [31:0] OPERAND_MAX = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_DIV,
        OP_POW,
        OP_MUL
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_cmd;
endpackage
`default_nettype wire

// File: design/pee_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/pee_alu.sv
// Iterative 32-bit multiply/divide/power unit; divides one bit per cycle.
// Depends on pee_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pee_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pee_pkg::t_alu_cmd i_cmd,
    input  wire logic [31:0]       i_left,
    input  wire logic [31:0]       i_right,
    output logic                   o_done,
    output logic [31:0]            o_result
);
    import pee_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_SQ,
        S_FIN
    } t_state;

    t_state        r_state;
    t_alu_op       r_op;
    logic [5:0]    r_cnt;
    logic [31:0]   r_a;
    logic [31:0]   r_b;
    logic [31:0]   r_acc;
    logic [31:0]   r_rem;
    logic          r_neg;
    logic [31:0]   r_res;
    logic          r_done;
    logic [32:0]   w_trial;
    logic [31:0]   w_prod;

    assign w_trial = {r_rem, r_a[31]} - {1'b0, r_b};
    assign w_prod  = r_acc * r_b;

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_op  <= i_cmd.op;
                        r_cnt <= 6'd0;
                        case (i_cmd.op)
                            OP_DIV: begin
                                r_a   <= i_left[31] ? 32'd0 - i_left : i_left;
                                r_b   <= i_right[31] ? 32'd0 - i_right : i_right;
                                r_neg <= i_left[31] ^ i_right[31];
                                r_rem <= 32'd0;
                            end
                            OP_POW: begin
                                r_a   <= i_right;
                                r_b   <= i_left;
                                r_acc <= 32'd1;
                            end
                            default: begin
                                r_acc <= i_left;
                                r_b   <= i_right;
                            end
                        endcase
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    case (r_op)
                        OP_DIV: begin
                            if (!w_trial[32]) begin
                                r_rem <= w_trial[31:0];
                                r_a   <= {r_a[30:0], 1'b1};
                            end else begin
                                r_rem <= {r_rem[30:0], r_a[31]};
                                r_a   <= {r_a[30:0], 1'b0};
                            end
                            r_cnt <= r_cnt + 6'd1;
                            if (r_cnt == 6'd31) begin
                                r_state <= S_FIN;
                            end
                        end
                        OP_POW: begin
                            if (r_a[31] || r_a == 32'd0) begin
                                r_state <= S_FIN;
                            end else begin
                                if (r_a[0]) begin
                                    r_acc <= w_prod;
                                end
                                r_a     <= {1'b0, r_a[31:1]};
                                r_state <= S_SQ;
                            end
                        end
                        default: begin
                            r_acc   <= w_prod;
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_SQ: begin
                    r_b     <= r_b * r_b;
                    r_state <= S_RUN;
                end
                S_FIN: begin
                    case (r_op)
                        OP_DIV:  r_res <= r_neg ? 32'd0 - r_a : r_a;
                        OP_POW:  r_res <= r_a[31] ? 32'd1 : r_acc;
                        default: r_res <= r_acc;
                    endcase
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule
`default_nettype wire

// File: design/postfix_expression_evaluator_top.sv
// Top level of the postfix expression evaluator.
// Depends on pee_pkg, pee_ram, pee_alu and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
// One transaction in is one character, and the input stays closed until that character is done.
// Plus and minus read both operands from the stack memory through its registered read port,
// and multiply, divide and power go to the iterative unit. An end-marked character leads to a
// single result transaction that carries the top of stack and the first error, and the next
// character waits until that result is taken.
`include "postfix_expression_evaluator_top_macros.svh"
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_end_of_expr,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [31:0] o_value,
    output logic [2:0]       o_status
);
    import pee_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_R,
        S_POP_L,
        S_GOT_R,
        S_GOT_L,
        S_EXEC,
        S_WAIT,
        S_PUSH,
        S_END,
        S_ENDRD,
        S_ENDWT,
        S_OUT
    } t_state;

    t_state         r_state;
    logic [CW-1:0]  r_count;
    logic [31:0]    r_acc;
    logic           r_pend;
    logic [2:0]     r_err;
    logic [7:0]     r_ch;
    logic           r_last;
    logic [31:0]    r_right;
    logic [31:0]    r_left;
    logic [31:0]    r_res;
    logic           r_rvalid;
    logic           r_lvalid;
    logic           r_ovalid;
    logic [31:0]    r_oval;
    logic [2:0]     r_ostat;
    logic           r_we;
    logic [AW-1:0]  r_waddr;
    logic [31:0]    r_wdata;
    logic [AW-1:0]  r_raddr;
    logic [31:0]    w_rdata;
    t_alu_cmd       r_cmd;
    logic           w_done;
    logic [31:0]    w_alu;
    logic [35:0]    w_next;
    logic           w_acc;
    logic [3:0]     w_digit;

    pee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata)
    );

    pee_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (r_cmd),
        .i_left   (r_left),
        .i_right  (r_right),
        .o_done   (w_done),
        .o_result (w_alu)
    );

    assign w_acc   = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign w_digit = i_char_code[3:0];
    assign w_next  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {32'd0, w_digit};

    always_ff @(posedge i_clk) begin
        r_we      <= 1'b0;
        r_cmd     <= '0;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_acc    <= '0;
            r_pend   <= 1'b0;
            r_err    <= ERR_NONE;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
            r_lvalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_ch   <= i_char_code;
                        r_last <= i_end_of_expr;
                        r_state <= i_end_of_expr ? S_END : S_IDLE;
                        if (i_char_code >= CH_ZERO && i_char_code <= CH_NINE) begin
                            r_pend <= 1'b1;
                            if (w_next > {4'd0, OPERAND_MAX}) begin
                                r_acc <= OPERAND_MAX;
                                if (r_err == ERR_NONE) r_err <= ERR_TOOLARGE;
                            end else begin
                                r_acc <= w_next[31:0];
                            end
                        end else if (i_char_code == CH_SPACE) begin
                            r_state <= S_END;
                        end else if (i_char_code == CH_PLUS || i_char_code == CH_MINUS
                                || i_char_code == CH_MUL || i_char_code == CH_DIV
                                || i_char_code == CH_POW) begin
                            r_state <= S_POP_R;
                        end
                    end
                end
                S_POP_R: begin
                    if (r_count == '0) begin
                        r_right <= 32'd0;
                        if (r_err == ERR_NONE) r_err <= ERR_UNDERFLOW;
                        r_state <= S_POP_L;
                        r_rvalid <= 1'b0;
                    end else begin
                        r_raddr  <= AW'(r_count - 1'b1);
                        r_count  <= r_count - 1'b1;
                        r_rvalid <= 1'b1;
                        r_state  <= S_POP_L;
                    end
                end
                S_POP_L: begin
                    if (r_count == '0) begin
                        r_left <= 32'd0;
                        if (r_err == ERR_NONE) r_err <= ERR_UNDERFLOW;
                        r_lvalid <= 1'b0;
                    end else begin
                        r_raddr  <= AW'(r_count - 1'b1);
                        r_count  <= r_count - 1'b1;
                        r_lvalid <= 1'b1;
                    end
                    r_state <= S_GOT_R;
                end
                S_GOT_R: begin
                    if (r_rvalid) r_right <= w_rdata;
                    r_state <= S_GOT_L;
                end
                S_GOT_L: begin
                    if (r_lvalid) r_left <= w_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (r_ch == CH_PLUS) begin
                        r_res <= r_left + r_right;
                        r_state <= S_PUSH;
                    end else if (r_ch == CH_MINUS) begin
                        r_res <= r_left - r_right;
                        r_state <= S_PUSH;
                    end else if (r_ch == CH_DIV && r_right == 32'd0) begin
                        r_res <= 32'd0;
                        if (r_err == ERR_NONE) r_err <= ERR_DIVZERO;
                        r_state <= S_PUSH;
                    end else begin
                        r_cmd.start <= 1'b1;
                        r_cmd.op <= (r_ch == CH_DIV) ? OP_DIV :
                                    (r_ch == CH_POW) ? OP_POW : OP_MUL;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_res   <= w_alu;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (r_count >= CW'(STACK_DEPTH)) begin
                        if (r_err == ERR_NONE) r_err <= ERR_OVERFLOW;
                    end else begin
                        r_we    <= 1'b1;
                        r_waddr <= AW'(r_count);
                        r_wdata <= r_res;
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= r_last ? S_END : S_IDLE;
                end
                S_END: begin
                    if (r_pend) begin
                        r_pend <= 1'b0;
                        r_acc  <= 32'd0;
                        if (r_count >= CW'(STACK_DEPTH)) begin
                            if (r_err == ERR_NONE) r_err <= ERR_OVERFLOW;
                        end else begin
                            r_we    <= 1'b1;
                            r_waddr <= AW'(r_count);
                            r_wdata <= r_acc;
                            r_count <= r_count + 1'b1;
                        end
                    end
                    r_state <= r_last ? S_ENDRD : S_IDLE;
                end
                S_ENDRD: begin
                    r_raddr <= AW'(r_count - 1'b1);
                    r_state <= r_we ? S_ENDRD : S_ENDWT;
                end
                S_ENDWT: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_oval   <= (r_count == '0) ? 32'd0 : w_rdata;
                    r_ostat  <= r_err;
                    r_ovalid <= 1'b1;
                    r_count  <= '0;
                    r_acc    <= '0;
                    r_pend   <= 1'b0;
                    r_err    <= ERR_NONE;
                    r_last   <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_value  = r_oval;
    assign o_status = r_ostat;

    `PEE_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_value))
    `PEE_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, r_count <= CW'(STACK_DEPTH))
    `PEE_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE |-> !o_ready)
endmodule
`default_nettype wire
